@@ src/bpas_pkg.sv @@
// ----------------------------------------------------------------------------
// bpas_pkg - button scanner shared definitions
// Field widths, register indexes, reset values and the structs passed
// between the top level and the per-channel state.
// ----------------------------------------------------------------------------
package bpas_pkg;

  // Fixed payload widths
  localparam int NUM_PINS   = 4;
  localparam int CH_W       = 2;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Item kinds
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_ENABLE = 3'd5;

  // Reset values
  localparam logic [CNT_W-1:0]    DETECT_TICKS_RST = 16'd60;
  localparam logic [CNT_W-1:0]    DELAY_TICKS_RST  = 16'd250;
  localparam logic [CNT_W-1:0]    REPEAT_TICKS_RST = 16'd200;
  localparam logic [NUM_PINS-1:0] ACTIVE_LEVEL_RST = 4'd0;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Autorepeat thresholds shared by every channel
  typedef struct packed {
    logic [CNT_W-1:0] detect_ticks;
    logic [CNT_W-1:0] delay_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } thr_t;

  // Per-channel status seen by the top level
  typedef struct packed {
    logic             down_next;
    logic             press_flag;
    logic             release_flag;
    logic             repeat_flag;
    logic [CNT_W-1:0] repeat_count;
  } chan_stat_t;

endpackage

@@ src/bpas_in_if.sv @@
// ----------------------------------------------------------------------------
// bpas_in_if - scanner item channel
// Valid/ready channel carrying one tick or query item.
// ----------------------------------------------------------------------------
interface bpas_in_if;
  import bpas_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [NUM_PINS-1:0] pin_levels;
  logic [CH_W-1:0]     channel;

  modport source (output valid, action, pin_levels, channel, input ready);
  modport sink   (input valid, action, pin_levels, channel, output ready);

endinterface

@@ src/bpas_out_if.sv @@
// ----------------------------------------------------------------------------
// bpas_out_if - scanner result channel
// Valid/ready channel carrying one result per item.
// ----------------------------------------------------------------------------
interface bpas_out_if;
  import bpas_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUM_PINS-1:0] pressed_mask;
  logic                press_seen;
  logic                release_seen;
  logic [CNT_W-1:0]    repeat_number;

  modport source (output valid, pressed_mask, press_seen, release_seen, repeat_number,
                  input ready);
  modport sink   (input valid, pressed_mask, press_seen, release_seen, repeat_number,
                  output ready);

endinterface

@@ src/bpas_channel.sv @@
// ----------------------------------------------------------------------------
// bpas_channel - one button channel
// Debounced-level edge detection, hold counter with three-stage autorepeat
// thresholds, saturating repeat count and sticky event flags.
// ----------------------------------------------------------------------------
module bpas_channel (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_go,
  input  logic               pressed,
  input  logic               clear,
  input  logic               events_enable,
  input  bpas_pkg::thr_t     thr,
  output bpas_pkg::chan_stat_t stat
);
  import bpas_pkg::*;

  logic             is_down;
  logic [CNT_W-1:0] hold_count;
  logic [CNT_W-1:0] repeat_count;
  logic             press_flag;
  logic             release_flag;
  logic             repeat_flag;

  logic [CNT_W-1:0] hold_inc;
  logic [CNT_W-1:0] threshold;
  logic             fire;

  assign hold_inc = hold_count + CNT_W'(1);

  // First repeat waits detect, second waits delay, later ones wait repeat
  always_comb begin
    priority if (repeat_count == CNT_W'(0)) begin
      threshold = thr.detect_ticks;
    end else if (repeat_count == CNT_W'(1)) begin
      threshold = thr.delay_ticks;
    end else begin
      threshold = thr.repeat_ticks;
    end
  end

  assign fire = (hold_inc >= threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      is_down      <= 1'b0;
      hold_count   <= '0;
      repeat_count <= '0;
      press_flag   <= 1'b0;
      release_flag <= 1'b0;
      repeat_flag  <= 1'b0;
    end else if (tick_go) begin
      if (pressed) begin
        if (!is_down) begin
          press_flag <= events_enable;
        end
        is_down <= 1'b1;
        if (fire) begin
          hold_count  <= '0;
          repeat_flag <= events_enable;
          if (repeat_count != CNT_MAX) begin
            repeat_count <= repeat_count + CNT_W'(1);
          end
        end else begin
          hold_count <= hold_inc;
        end
      end else begin
        // Hold counter keeps its value across a release
        if (is_down) begin
          release_flag <= events_enable;
        end
        is_down      <= 1'b0;
        repeat_count <= '0;
      end
    end else if (clear) begin
      press_flag   <= 1'b0;
      release_flag <= 1'b0;
      repeat_flag  <= 1'b0;
    end
  end

  always_comb begin
    stat.down_next    = tick_go ? pressed : is_down;
    stat.press_flag   = press_flag;
    stat.release_flag = release_flag;
    stat.repeat_flag  = repeat_flag;
    stat.repeat_count = repeat_count;
  end

endmodule

@@ src/button_press_autorepeat_scanner.sv @@
// ----------------------------------------------------------------------------
// button_press_autorepeat_scanner - key scanner with typematic autorepeat
// Samples button pins on tick transactions, latches press, release and
// repeat events per channel, and reports and clears them on queries.
// ----------------------------------------------------------------------------
// Each transaction on items is either a tick (sample every pin) or a query
// (read and clear one channel's latched events); every transaction yields
// exactly one result transaction. The block takes one transaction per clock
// cycle while results.ready lets the result register drain; a transaction
// is held in the input register and then in the result register. Only
// results.ready holds the flow back: the input register and the result
// register together act as a two-entry pipeline, so a new transaction is
// still taken into an empty input register while a finished result waits to
// be taken. Channel state (level, hold counter, repeat counter, event flags)
// lives in flops, one bpas_channel per button, all updated in parallel when
// the transaction in the input register moves to the result register.
// Configuration writes are taken at any cycle with cfg_wr_en high and must
// only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module button_press_autorepeat_scanner #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [bpas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpas_pkg::CFG_DATA_W-1:0]     cfg_data,
  bpas_in_if.sink                             items,
  bpas_out_if.source                          results
);
  import bpas_pkg::*;

  // Configuration registers
  thr_t                thr;
  logic [NUM_PINS-1:0] active_level_mask;
  logic                query_enable;
  logic                events_enable;

  // Input register
  logic                s1_valid;
  logic                s1_action;
  logic [NUM_PINS-1:0] s1_pins;
  logic [CH_W-1:0]     s1_channel;

  logic advance;
  logic tick_go;
  logic query_go;

  chan_stat_t stat [NUM_BUTTONS];
  chan_stat_t qview [NUM_PINS];
  chan_stat_t qsel;

  logic [NUM_PINS-1:0] down_view;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.detect_ticks  <= DETECT_TICKS_RST;
      thr.delay_ticks   <= DELAY_TICKS_RST;
      thr.repeat_ticks  <= REPEAT_TICKS_RST;
      active_level_mask <= ACTIVE_LEVEL_RST;
      query_enable      <= 1'b1;
      events_enable     <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DETECT_TICKS:  thr.detect_ticks  <= cfg_data;
        CFG_DELAY_TICKS:   thr.delay_ticks   <= cfg_data;
        CFG_REPEAT_TICKS:  thr.repeat_ticks  <= cfg_data;
        CFG_ACTIVE_LEVEL:  active_level_mask <= cfg_data[NUM_PINS-1:0];
        CFG_QUERY_ENABLE:  query_enable      <= cfg_data[0];
        CFG_EVENTS_ENABLE: events_enable     <= cfg_data[0];
        default: begin
          // Drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Advance the input register whenever the result register is free or
  // being emptied this cycle.
  assign advance     = s1_valid && (!results.valid || results.ready);
  assign items.ready = !s1_valid || advance;
  assign tick_go     = advance && (s1_action == ACT_TICK);
  assign query_go    = advance && (s1_action == ACT_QUERY) && query_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_action  <= items.action;
      s1_pins    <= items.pin_levels;
      s1_channel <= items.channel;
    end
  end

  // One channel per button. Channels without a pin are tied to pressed, so
  // they count as held; only channels reachable by the query field get a
  // clear.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_chan
    logic pressed;
    logic clear;

    if (i < NUM_PINS) begin : g_pin
      assign pressed = (s1_pins[i] == active_level_mask[i]);
      assign clear   = query_go && (s1_channel == CH_W'(i));
    end else begin : g_nopin
      assign pressed = 1'b1;
      assign clear   = 1'b0;
    end

    bpas_channel u_chan (
      .clk           (clk),
      .rst           (rst),
      .tick_go       (tick_go),
      .pressed       (pressed),
      .clear         (clear),
      .events_enable (events_enable),
      .thr           (thr),
      .stat          (stat[i])
    );
  end

  // Query view over the channel field's range; missing channels read zero
  for (genvar j = 0; j < NUM_PINS; j++) begin : g_view
    if (j < NUM_BUTTONS) begin : g_real
      assign qview[j]     = stat[j];
      assign down_view[j] = stat[j].down_next;
    end else begin : g_absent
      assign qview[j]     = '0;
      assign down_view[j] = 1'b0;
    end
  end

  assign qsel = qview[s1_channel];

  // Result register: pressed_mask reflects the state after this item,
  // event fields reflect the flags before the query clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.pressed_mask  <= query_enable ? down_view : '0;
      results.press_seen    <= query_go && qsel.press_flag;
      results.release_seen  <= query_go && qsel.release_flag;
      results.repeat_number <= (query_go && qsel.repeat_flag) ? qsel.repeat_count : '0;
    end
  end

endmodule

@@ sim/button_press_autorepeat_scanner_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_autorepeat_scanner_tb - self-checking bench for the scanner
// Drives tick and query transactions through the item channel and checks
// every report against a cycle-free model of the channel state kept here.
// It covers directed edge, polarity, timing and enable cases, a long result
// stall, and random held-button traffic across several register settings,
// with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module button_press_autorepeat_scanner_tb;
  import bpas_pkg::*;

  localparam int NUM_BUTTONS    = 4;
  localparam int QUIET_LIMIT    = 2000;  // several times the longest legal quiet stretch
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 4;     // settle time after the last report, with margin
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 250;

  // One report as seen on the result channel
  typedef struct packed {
    logic [NUM_PINS-1:0] pressed_mask;
    logic                press_seen;
    logic                release_seen;
    logic [CNT_W-1:0]    repeat_number;
  } scan_report_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bpas_in_if  item_ch ();
  bpas_out_if result_ch ();

  button_press_autorepeat_scanner #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (item_ch),
    .results  (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the scanner: register copies and per-channel state
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]    detect_cfg = DETECT_TICKS_RST;
  logic [CNT_W-1:0]    delay_cfg  = DELAY_TICKS_RST;
  logic [CNT_W-1:0]    repeat_cfg = REPEAT_TICKS_RST;
  logic [NUM_PINS-1:0] level_cfg  = ACTIVE_LEVEL_RST;
  logic                query_cfg  = 1'b1;
  logic                events_cfg = 1'b1;

  logic [NUM_PINS-1:0] btn_down   = '0;
  logic [NUM_PINS-1:0] press_ev   = '0;
  logic [NUM_PINS-1:0] release_ev = '0;
  logic [NUM_PINS-1:0] repeat_ev  = '0;
  logic [CNT_W-1:0]    hold_cnt [NUM_BUTTONS] = '{default: '0};
  logic [CNT_W-1:0]    rep_cnt  [NUM_BUTTONS] = '{default: '0};

  scan_report_t pending_reports[$];

  // Bookkeeping for the summary and the verdict
  int mismatches      = 0;
  int ticks_sent      = 0;
  int queries_sent    = 0;
  int reports_checked = 0;
  int repeats_owed    = 0;

  // Sender pacing and receiver hold-off controls
  bit bursty        = 1'b1;
  int burst_left    = 0;
  bit stall_request = 1'b0;
  int stall_left    = 0;
  int rx_cycle      = 0;
  int quiet_cycles  = 0;

  // Advance the model by one transaction and return the report it owes.
  function automatic scan_report_t apply_item(input logic act,
                                              input logic [NUM_PINS-1:0] pins,
                                              input logic [CH_W-1:0] ch);
    scan_report_t     r;
    logic [CNT_W-1:0] thr;
    r = '0;
    if (act == ACT_TICK) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (pins[i] == level_cfg[i]) begin
          if (!btn_down[i]) press_ev[i] = events_cfg;
          btn_down[i] = 1'b1;
          hold_cnt[i] = hold_cnt[i] + 1'b1;
          // First repeat waits detect, second waits delay, the rest repeat
          if (rep_cnt[i] == '0) thr = detect_cfg;
          else if (rep_cnt[i] == CNT_W'(1)) thr = delay_cfg;
          else thr = repeat_cfg;
          if (hold_cnt[i] >= thr) begin
            hold_cnt[i] = '0;
            if (rep_cnt[i] != CNT_MAX) rep_cnt[i] = rep_cnt[i] + 1'b1;
            repeat_ev[i] = events_cfg;
          end
        end else begin
          // Release keeps the hold counter, drops the repeat count
          if (btn_down[i]) release_ev[i] = events_cfg;
          btn_down[i] = 1'b0;
          rep_cnt[i]  = '0;
        end
      end
    end else if (query_cfg) begin
      r.press_seen    = press_ev[ch];
      r.release_seen  = release_ev[ch];
      r.repeat_number = repeat_ev[ch] ? rep_cnt[ch] : '0;
      press_ev[ch]    = 1'b0;
      release_ev[ch]  = 1'b0;
      repeat_ev[ch]   = 1'b0;
    end
    if (query_cfg) r.pressed_mask = btn_down;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers; all are entered right after a rising edge
  // --------------------------------------------------------------------------

  // Offer one transaction, with an occasional gap between bursts, and hold
  // it until the block takes it; then log the report it owes.
  task automatic send_item(input logic act, input logic [NUM_PINS-1:0] pins,
                           input logic [CH_W-1:0] ch);
    int           gap;
    scan_report_t owed;
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
      end
      burst_left--;
    end
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.pin_levels <= pins;
    item_ch.channel    <= ch;
    do @(posedge clk); while (!item_ch.ready);
    owed = apply_item(act, pins, ch);
    pending_reports.push_back(owed);
    if (act == ACT_TICK) ticks_sent++;
    else queries_sent++;
    if (owed.repeat_number != '0) repeats_owed++;
  endtask

  task automatic tick(input logic [NUM_PINS-1:0] pins);
    send_item(ACT_TICK, pins, CH_W'($urandom_range(0, 3)));
  endtask

  task automatic query(input logic [CH_W-1:0] ch);
    send_item(ACT_QUERY, NUM_PINS'($urandom_range(0, 15)), ch);
  endtask

  // Drop valid and wait until every owed report has come back, then let
  // the pipeline settle so register writes land on an idle block.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DETECT_TICKS:  detect_cfg = value;
      CFG_DELAY_TICKS:   delay_cfg  = value;
      CFG_REPEAT_TICKS:  repeat_cfg = value;
      CFG_ACTIVE_LEVEL:  level_cfg  = value[NUM_PINS-1:0];
      CFG_QUERY_ENABLE:  query_cfg  = value[0];
      CFG_EVENTS_ENABLE: events_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CNT_W-1:0] det, input logic [CNT_W-1:0] dly,
                            input logic [CNT_W-1:0] rpt);
    write_reg(CFG_DETECT_TICKS, det);
    write_reg(CFG_DELAY_TICKS, dly);
    write_reg(CFG_REPEAT_TICKS, rpt);
  endtask

  task automatic set_mode(input logic [NUM_PINS-1:0] mask, input logic q_en,
                          input logic e_en);
    write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(mask));
    write_reg(CFG_QUERY_ENABLE, CFG_DATA_W'(q_en));
    write_reg(CFG_EVENTS_ENABLE, CFG_DATA_W'(e_en));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: active level 0, so a low pin means pressed.
  task automatic test_edges_and_queries();
    tick(4'hF);
    tick(4'h0);
    send_item(ACT_QUERY, 4'hF, 2'd0);
    tick(4'hF);
    send_item(ACT_QUERY, 4'h0, 2'd1);
    send_item(ACT_QUERY, 4'hA, 2'd3);
  endtask

  // Flip the polarity so high pins mean pressed; press and release in pairs.
  task automatic test_polarity();
    drain();
    set_mode(4'hF, 1'b1, 1'b1);
    tick(4'b0101);
    query(2'd0);
    tick(4'b1010);
    query(2'd2);
    query(2'd3);
  endtask

  // Short thresholds: hold count survives a release, and a repeat flag
  // latched before a release reads back with the cleared count.
  task automatic test_repeat_timing();
    drain();
    set_timing(16'd4, 16'd3, 16'd1);
    tick(4'b0010);
    tick(4'b0010);
    tick(4'b0000);
    repeat (4) tick(4'b0010);
    tick(4'b0000);
    query(2'd1);
  endtask

  // Zero thresholds fire a repeat on every held tick.
  task automatic test_zero_thresholds();
    drain();
    set_timing('0, '0, '0);
    tick(4'hF);
    tick(4'hF);
    query(2'd3);
  endtask

  // With events off, edges and repeats latch their flags as zero.
  task automatic test_events_disabled();
    drain();
    set_mode(4'hF, 1'b1, 1'b0);
    tick(4'h0);
    tick(4'hF);
    query(2'd0);
  endtask

  // With queries off everything reads zero and nothing is cleared.
  task automatic test_queries_disabled();
    drain();
    set_mode(4'hF, 1'b0, 1'b1);
    tick(4'h0);
    query(2'd2);
    drain();
    write_reg(CFG_QUERY_ENABLE, CFG_DATA_W'(1'b1));
    query(2'd2);
  endtask

  // Stall the receiver for a long stretch while items keep coming, so the
  // block fills and pushes back on its input.
  task automatic test_receiver_holdoff();
    drain();
    set_timing(16'd3, 16'd2, 16'd1);
    stall_request = 1'b1;
    for (int n = 0; n < 24; n++) begin
      if (n % 4 == 3) query(CH_W'($urandom_range(0, 3)));
      else tick(NUM_PINS'($urandom_range(0, 15)));
    end
  endtask

  // Random traffic: buttons mostly stay put and flip now and then, so holds
  // run long enough to reach the thresholds; some ticks are pure noise.
  task automatic test_random_traffic();
    logic [NUM_PINS-1:0] held;
    logic [NUM_PINS-1:0] pins;
    int                  roll;
    held = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          set_timing(16'd2, 16'd5, 16'd1);
          set_mode(4'hF, 1'b1, 1'b1);
        end
        1: begin
          set_timing(CNT_W'($urandom_range(0, 12)), CNT_W'($urandom_range(0, 12)),
                     CNT_W'($urandom_range(0, 12)));
          set_mode(NUM_PINS'($urandom_range(0, 15)), 1'b1, 1'b1);
        end
        2: begin
          set_timing('0, '0, '0);
          set_mode(4'h0, 1'b1, 1'b1);
        end
        3: begin
          set_timing(CNT_MAX, CNT_MAX, CNT_MAX);
          set_mode(4'h5, 1'b1, 1'b1);
        end
        4: begin
          set_timing(CNT_W'($urandom_range(0, 8)), CNT_W'($urandom_range(0, 8)),
                     CNT_W'($urandom_range(0, 8)));
          set_mode(NUM_PINS'($urandom_range(0, 15)), 1'b1, 1'b0);
        end
        5: begin
          set_timing(CNT_W'($urandom_range(0, 40)), CNT_W'($urandom_range(0, 8)),
                     CNT_W'($urandom_range(0, 4)));
          set_mode(NUM_PINS'($urandom_range(0, 15)), 1'b0, 1'b1);
        end
        default: begin
          set_timing(CNT_W'($urandom_range(0, 10)), CNT_W'($urandom_range(0, 10)),
                     CNT_W'($urandom_range(0, 3)));
          set_mode(NUM_PINS'($urandom_range(0, 15)), 1'b1, 1'b1);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          query(CH_W'($urandom_range(0, 3)));
        end else begin
          if (roll < 33) begin
            pins = NUM_PINS'($urandom_range(0, 15));
          end else begin
            for (int b = 0; b < NUM_PINS; b++)
              if ($urandom_range(0, 11) == 0) held[b] = ~held[b];
            // A held button drives its active level, a free one the other
            pins = ~(held ^ level_cfg);
          end
          tick(pins);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    logic rdy;
    rx_cycle++;
    if (stall_request) begin
      stall_left    = HOLDOFF_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      // Rotate through always-ready, random, periodic and sticky stalls
      case ((rx_cycle >> 8) % 4)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 9) < 7);
        2:       rdy = ((rx_cycle % 8) >= 3);
        default: rdy = ($urandom_range(0, 5) == 0) ? ~result_ch.ready : result_ch.ready;
      endcase
    end
    result_ch.ready <= rdy;
  end

  // --------------------------------------------------------------------------
  // Checker: compare each taken report with the oldest owed one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    scan_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      reports_checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Report with nothing owed: mask=%h press=%b release=%b repeat=%0d",
                   result_ch.pressed_mask, result_ch.press_seen, result_ch.release_seen,
                   result_ch.repeat_number);
      end else begin
        want = pending_reports.pop_front();
        if (result_ch.pressed_mask !== want.pressed_mask ||
            result_ch.press_seen !== want.press_seen ||
            result_ch.release_seen !== want.release_seen ||
            result_ch.repeat_number !== want.repeat_number) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Report %0d mismatch: expected mask=%h press=%b release=%b repeat=%0d, %s",
                     reports_checked, want.pressed_mask, want.press_seen, want.release_seen,
                     want.repeat_number,
                     $sformatf("got mask=%h press=%b release=%b repeat=%0d",
                               result_ch.pressed_mask, result_ch.press_seen,
                               result_ch.release_seen, result_ch.repeat_number));
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[button_press_autorepeat_scanner] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    item_ch.valid      = 1'b0;
    item_ch.action     = ACT_TICK;
    item_ch.pin_levels = '0;
    item_ch.channel    = '0;
    result_ch.ready    = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edges_and_queries();
    test_polarity();
    test_repeat_timing();
    test_zero_thresholds();
    test_events_disabled();
    test_queries_disabled();
    test_receiver_holdoff();
    test_random_traffic();

    // Let the last reports come back, then let the block settle
    drain();

    $display("Scanner run: %0d ticks and %0d queries sent, %0d reports checked",
             ticks_sent, queries_sent, reports_checked);
    $display("Scanner run: %0d queries carried a repeat count, %0d mismatches",
             repeats_owed, mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[button_press_autorepeat_scanner] OK");
    end else begin
      $display("[button_press_autorepeat_scanner] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bpas_pkg.sv
src/bpas_in_if.sv
src/bpas_out_if.sv
src/bpas_channel.sv
src/button_press_autorepeat_scanner.sv
sim/button_press_autorepeat_scanner_tb.sv
